/* hw/rtl/wre_pkg.sv */
// ----------------------------------------------------------------------------
// wre_pkg
// Shared types and constants for the wall run extractor: register codes,
// result record, counter limits and output queue sizing.
// ----------------------------------------------------------------------------
package wre_pkg;

  localparam int REG_W = 9;                   // width of sizes, counters, coords
  localparam int MAX_HEIGHT = 256;            // largest usable map height
  localparam int H_LIM = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

  localparam logic [REG_W-1:0] MIN_RUN = 9'd2;
  localparam logic [REG_W-1:0] CNT_MAX = 9'h1FF;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = FIFO_PTR_W + 1;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             is_vertical;
    logic [REG_W-1:0] rect_x;
    logic [REG_W-1:0] rect_y;
    logic [REG_W-1:0] rect_width;
    logic [REG_W-1:0] rect_height;
    logic             last;
  } rect_t;

endpackage

/* hw/rtl/wre_ram.sv */
// ----------------------------------------------------------------------------
// wre_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module wre_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/wre_out_fifo.sv */
// ----------------------------------------------------------------------------
// wre_out_fifo
// Result queue: takes up to two rectangles a cycle, hands out one a cycle
// on a valid/ready port and reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module wre_out_fifo
  import wre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push0,
  input  rect_t                 data0,
  input  logic                  push1,
  input  rect_t                 data1,
  output logic                  pop_valid,
  output rect_t                 pop_data,
  input  logic                  pop_ready,
  output logic [FIFO_LVL_W-1:0] level
);

  rect_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_LVL_W-1:0]  level_r, level_nxt;
  logic [FIFO_PTR_W-1:0]  wr_ptr_p1;
  logic [1:0]             push_cnt;
  logic                   pop;

  assign pop       = pop_valid && pop_ready;
  assign push_cnt  = {1'b0, push0} + {1'b0, push1};
  assign wr_ptr_p1 = wr_ptr_r + FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    level_nxt  = level_r + FIFO_LVL_W'(push_cnt) - FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= data0;
    end
    if (push1) begin
      mem_r[wr_ptr_p1] <= data1;
    end
  end

  assign pop_valid = (level_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign level     = level_r;

endmodule

/* hw/rtl/wall_run_extractor.sv */
// ----------------------------------------------------------------------------
// wall_run_extractor
// A tile's rectangles are registered in the column stage, then queued.
// Throughput: one tile per cycle while in_ready is high; the column counter
// memory is read when a tile is taken and written back the next cycle, with
// forwarding between neighbors. The output port moves one rectangle a cycle
// while out_ready is high, so tiles that raise two rectangles back up the
// input as the queue fills. Reset and every map_width or map_height write
// start a clearing pass over the column memory; in_ready stays low during it.
// ----------------------------------------------------------------------------
module wall_run_extractor
  import wre_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_is_wall,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_vertical,
  output logic [REG_W-1:0] out_rect_x,
  output logic [REG_W-1:0] out_rect_y,
  output logic [REG_W-1:0] out_rect_width,
  output logic [REG_W-1:0] out_rect_height,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int W_LIM = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;

  // configuration
  logic [REG_W-1:0] map_width_r, map_width_nxt;
  logic [REG_W-1:0] map_height_r, map_height_nxt;
  logic             cfg_hit;
  logic [REG_W-1:0] w_eff, h_eff;

  // clearing pass
  logic             clr_active_r, clr_active_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;

  // scan position and row counter
  logic [REG_W-1:0] col_pos_r, col_pos_nxt;
  logic [REG_W-1:0] row_pos_r, row_pos_nxt;
  logic [REG_W-1:0] row_run_r, row_run_nxt;
  logic             accept;
  logic             last_col, last_row;
  logic [REG_W-1:0] rr_inc;
  logic             h_emit;
  logic [REG_W-1:0] h_x, h_len;

  // column stage
  logic             s1_valid_r;
  logic             s1_wall_r;
  logic             s1_last_row_r;
  logic [REG_W-1:0] s1_col_r, s1_row_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_h_emit_r;
  logic [REG_W-1:0] s1_h_x_r, s1_h_len_r;
  logic             fwd_hit_r;
  logic [REG_W-1:0] fwd_data_r;

  logic [AW-1:0]    rd_addr;
  logic [REG_W-1:0] ram_rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REG_W-1:0] ram_wdata;

  logic [REG_W-1:0] v_old, v_inc, v_new, v_len, v_y;
  logic             v_emit;
  rect_t            h_rect, v_rect, push0_data, push1_data;
  logic             push0, push1;

  logic                  fifo_valid;
  rect_t                 fifo_data;
  logic [FIFO_LVL_W-1:0] fifo_level;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    cfg_hit        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAP_WIDTH: begin
          map_width_nxt = cfg_wdata;
          cfg_hit       = 1'b1;
        end
        REG_MAP_HEIGHT: begin
          map_height_nxt = cfg_wdata;
          cfg_hit        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = map_width_r;
    if (map_width_r == '0) begin
      w_eff = 9'd1;
    end else if (map_width_r > 9'(W_LIM)) begin
      w_eff = 9'(W_LIM);
    end
    h_eff = map_height_r;
    if (map_height_r == '0) begin
      h_eff = 9'd1;
    end else if (map_height_r > 9'(H_LIM)) begin
      h_eff = 9'(H_LIM);
    end
  end

  // --------------------------------------------------------------------------
  // clearing pass over the column memory
  // --------------------------------------------------------------------------
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (cfg_hit) begin
      clr_active_nxt = 1'b1;
      clr_addr_nxt   = '0;
    end else if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // input stage: position, horizontal run, column read
  // --------------------------------------------------------------------------
  // hold off while the queue may not have room for this tile and the one ahead
  assign in_ready = !clr_active_r &&
                    ((FIFO_LVL_W + 1)'(fifo_level) + (FIFO_LVL_W + 1)'({s1_valid_r, 1'b0})
                     <= (FIFO_LVL_W + 1)'(FIFO_DEPTH - 2));
  assign accept   = in_valid && in_ready;

  assign last_col = (col_pos_r + 9'd1) >= w_eff;
  assign last_row = (row_pos_r + 9'd1) >= h_eff;
  assign rr_inc   = (row_run_r == CNT_MAX) ? row_run_r : row_run_r + 9'd1;
  assign rd_addr  = AW'(col_pos_r);

  always_comb begin
    h_emit      = 1'b0;
    h_x         = col_pos_r;
    h_len       = row_run_r;
    row_run_nxt = row_run_r;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (cfg_hit) begin
      row_run_nxt = '0;
      col_pos_nxt = '0;
      row_pos_nxt = '0;
    end else if (accept) begin
      if (in_is_wall) begin
        if (last_col) begin
          h_emit      = rr_inc > MIN_RUN;
          h_x         = w_eff;
          h_len       = rr_inc;
          row_run_nxt = '0;
        end else begin
          row_run_nxt = rr_inc;
        end
      end else begin
        h_emit      = row_run_r > MIN_RUN;
        row_run_nxt = '0;
      end
      if (last_col) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + 9'd1;
      end else begin
        col_pos_nxt = col_pos_r + 9'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // column stage: read-modify-write of the column counter
  // --------------------------------------------------------------------------
  assign v_old = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign v_inc = (v_old == CNT_MAX) ? v_old : v_old + 9'd1;

  always_comb begin
    v_emit = 1'b0;
    v_len  = v_old;
    v_new  = '0;
    v_y    = s1_row_r;
    if (s1_wall_r) begin
      if (s1_last_row_r) begin
        v_emit = v_inc > MIN_RUN;
        v_len  = v_inc;
        v_y    = h_eff;
      end else begin
        v_new = v_inc;
      end
    end else begin
      v_emit = v_old > MIN_RUN;
    end
  end

  always_comb begin
    ram_we    = clr_active_r || s1_valid_r;
    ram_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
    ram_wdata = clr_active_r ? '0 : v_new;
  end

  wre_ram #(
    .WIDTH (REG_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    h_rect.is_vertical = 1'b0;
    h_rect.rect_x      = s1_h_x_r;
    h_rect.rect_y      = s1_row_r + 9'd1;
    h_rect.rect_width  = s1_h_len_r;
    h_rect.rect_height = 9'd1;
    h_rect.last        = !v_emit;

    v_rect.is_vertical = 1'b1;
    v_rect.rect_x      = s1_col_r + 9'd1;
    v_rect.rect_y      = v_y;
    v_rect.rect_width  = 9'd1;
    v_rect.rect_height = v_len;
    v_rect.last        = 1'b1;

    push0      = s1_valid_r && (s1_h_emit_r || v_emit);
    push1      = s1_valid_r && s1_h_emit_r && v_emit;
    push0_data = s1_h_emit_r ? h_rect : v_rect;
    push1_data = v_rect;
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 9'd32;
      map_height_r <= 9'd32;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      col_pos_r    <= '0;
      row_pos_r    <= '0;
      row_run_r    <= '0;
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      col_pos_r    <= col_pos_nxt;
      row_pos_r    <= row_pos_nxt;
      row_run_r    <= row_run_nxt;
      s1_valid_r   <= accept;
      // the write in this cycle is not yet seen by the read issued alongside
      fwd_hit_r    <= accept && s1_valid_r && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= v_new;
    if (accept) begin
      s1_wall_r     <= in_is_wall;
      s1_last_row_r <= last_row;
      s1_col_r      <= col_pos_r;
      s1_row_r      <= row_pos_r;
      s1_addr_r     <= rd_addr;
      s1_h_emit_r   <= h_emit;
      s1_h_x_r      <= h_x;
      s1_h_len_r    <= h_len;
    end
  end

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  wre_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .data0     (push0_data),
    .push1     (push1),
    .data1     (push1_data),
    .pop_valid (fifo_valid),
    .pop_data  (fifo_data),
    .pop_ready (out_ready),
    .level     (fifo_level)
  );

  assign out_valid       = fifo_valid;
  assign out_is_vertical = fifo_data.is_vertical;
  assign out_rect_x      = fifo_data.rect_x;
  assign out_rect_y      = fifo_data.rect_y;
  assign out_rect_width  = fifo_data.rect_width;
  assign out_rect_height = fifo_data.rect_height;
  assign out_last        = fifo_data.last;

`ifndef SYNTHESIS
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= FIFO_LVL_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ready)
    else $error("request taken during clearing pass");

  a_no_rmw_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !clr_active_r)
    else $error("column write-back overlaps clearing pass");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_pos_r < w_eff) && (row_pos_r < h_eff))
    else $error("scan position outside the map");
`endif

endmodule

/* verif/tb_wall_run_extractor.sv */
// ----------------------------------------------------------------------------
// tb_wall_run_extractor
// Streams binary wall maps into the run extractor under random valid/ready
// idling and checks every rectangle against a scan-order run predictor.
// Map sizes are changed between phases: zero, one, full size and oversize
// values, plus a long receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_wall_run_extractor;
  import wre_pkg::*;

  localparam int MAX_W         = 256;
  localparam int IDLE_PCT      = 28;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_TILES  = 1600;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic             in_is_wall  = 1'b0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic             out_is_vertical;
  logic [REG_W-1:0] out_rect_x;
  logic [REG_W-1:0] out_rect_y;
  logic [REG_W-1:0] out_rect_width;
  logic [REG_W-1:0] out_rect_height;
  logic             out_last;
  logic             cfg_we      = 1'b0;
  logic [0:0]       cfg_index   = 1'b0;
  logic [REG_W-1:0] cfg_wdata   = '0;

  wall_run_extractor #(.MAX_WIDTH(MAX_W)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_is_wall      (in_is_wall),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_vertical (out_is_vertical),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pending tiles, expected rectangles, bookkeeping
  logic  tile_q[$];
  rect_t rect_q[$];
  int    tiles_left = 0;
  int    rects_seen = 0;
  int    errors     = 0;
  int    hold_cnt   = 0;
  bit    hold_done  = 1'b0;
  bit    no_idle    = 1'b0;
  bit    in_taken   = 1'b0;

  // scan state mirrored from the block
  int               map_w;
  int               map_h;
  logic [REG_W-1:0] col_run [MAX_W];
  logic [REG_W-1:0] row_run;
  int               col_pos;
  int               row_pos;

  function automatic void clear_frame();
    foreach (col_run[i]) col_run[i] = '0;
    row_run = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int clamp_size(int v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return v;
  endfunction

  // Work out the rectangles closed by one tile and advance the scan position.
  task automatic extract_runs(input logic wall);
    int    w, h, c, r, n;
    bit    last_col, last_row;
    rect_t found [2];
    w = clamp_size(map_w);
    h = clamp_size(map_h);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    n = 0;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);

    if (wall) begin
      if (row_run < CNT_MAX) row_run++;
      if (last_col) begin
        if (row_run > MIN_RUN) begin
          found[n] = '{1'b0, 9'(w), 9'(r + 1), row_run, 9'd1, 1'b0};
          n++;
        end
        row_run = '0;
      end
    end else begin
      if (row_run > MIN_RUN) begin
        found[n] = '{1'b0, 9'(c), 9'(r + 1), row_run, 9'd1, 1'b0};
        n++;
      end
      row_run = '0;
    end

    // a column run ends at a floor tile or on the bottom row
    if (wall) begin
      if (col_run[c] < CNT_MAX) col_run[c]++;
      if (last_row) begin
        if (col_run[c] > MIN_RUN) begin
          found[n] = '{1'b1, 9'(c + 1), 9'(h), 9'd1, col_run[c], 1'b0};
          n++;
        end
        col_run[c] = '0;
      end
    end else begin
      if (col_run[c] > MIN_RUN) begin
        found[n] = '{1'b1, 9'(c + 1), 9'(r), 9'd1, col_run[c], 1'b0};
        n++;
      end
      col_run[c] = '0;
    end

    if (n > 0) found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) rect_q.insert(rect_q.size(), found[i]);

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  function automatic void check_field(string name, logic [REG_W-1:0] want,
                                      logic [REG_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // accepted tile requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      extract_runs(in_is_wall);
      tiles_left--;
      in_taken = 1'b1;
    end
  end

  // tile driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (tile_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid   <= 1'b1;
        in_is_wall <= tile_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // rectangle receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (!hold_done && rects_seen >= 150 && tiles_left >= 30) begin
      hold_done = 1'b1;
      hold_cnt  = 120;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // rectangle monitor
  always @(posedge clk) begin : rect_mon
    rect_t got;
    rect_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_is_vertical, out_rect_x, out_rect_y, out_rect_width,
              out_rect_height, out_last};
      rects_seen++;
      if (rect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected rectangle: expected none, got %p", $time, got);
      end else begin
        want = rect_q.pop_front();
        check_field("is_vertical", REG_W'(want.is_vertical), REG_W'(got.is_vertical));
        check_field("rect_x", want.rect_x, got.rect_x);
        check_field("rect_y", want.rect_y, got.rect_y);
        check_field("rect_width", want.rect_width, got.rect_width);
        check_field("rect_height", want.rect_height, got.rect_height);
        check_field("last", REG_W'(want.last), REG_W'(got.last));
      end
    end
  end

  task automatic add_tile(input logic wall);
    tile_q.insert(tile_q.size(), wall);
    tiles_left++;
  endtask

  // wait until every tile is taken and every rectangle has come out
  task automatic settle();
    while (tiles_left > 0 || rect_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    // hold while the column memory clear is still running
    while (!in_ready) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 9'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAP_WIDTH) map_w = val & 'h1FF;
    else map_h = val & 'h1FF;
    clear_frame();
    @(negedge clk);
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 256;
      2:       return $urandom_range(257, 511);
      3:       return $urandom_range(13, 64);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin : stim
    logic [19:0] pattern;
    int          total, phase, w, h, n, dens, len, sel;
    logic        wall;
    map_w = 32;
    map_h = 32;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: a row run closed by a floor tile
    repeat (4) add_tile(1'b1);
    add_tile(1'b0);
    settle();

    // 4x5 map, one full frame: column 0 closed by floor, column runs closed on
    // the bottom row, its last tile giving two rectangles, then frame wrap
    write_reg(REG_MAP_WIDTH, 4);
    write_reg(REG_MAP_HEIGHT, 5);
    pattern = 20'b1111_1111_1111_0111_1111;
    for (int i = 19; i >= 0; i--) add_tile(pattern[i]);
    settle();

    total = 0;
    phase = 0;
    while (total < RANDOM_TILES) begin
      if (phase == 0) begin
        w = 0;
        h = 511;
        sel = 0;
      end else if (phase == 1) begin
        w = 256;
        h = 1;
        sel = 0;
      end else begin
        w = pick_size();
        h = pick_size();
        sel = $urandom_range(0, 3);
      end
      if (sel == 0 || sel == 1) write_reg(REG_MAP_WIDTH, w);
      if (sel == 0 || sel == 2) write_reg(REG_MAP_HEIGHT, h);
      no_idle = (phase == 4);

      n = $urandom_range(40, 140);
      dens = $urandom_range(30, 95);
      if ($urandom_range(0, 1) == 0) begin
        for (int i = 0; i < n; i++) add_tile($urandom_range(99) < dens);
      end else begin
        // alternate wall runs and short floor gaps
        len = 0;
        wall = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (len == 0) begin
            wall = ~wall;
            len = wall ? $urandom_range(1, 8) : $urandom_range(1, 3);
          end
          add_tile(wall);
          len--;
        end
      end
      total += n;
      settle();
      phase++;
    end
    no_idle = 1'b0;

    if (errors == 0 && rect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
